// ----- rtl/mqpd_pkg.sv -----
// Shared request and result codes for the multi-queue priority deque.
`default_nettype none

package mqpd_pkg;

    // Request kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_URGENT = 2'd1,
        KIND_TAKE   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    // Result outcomes carried on the output tuser field.
    typedef enum logic [1:0] {
        OUT_ADDED = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_TAKEN = 2'd2,
        OUT_EMPTY = 2'd3
    } outcome_t;

    localparam int KIND_W    = 2;
    localparam int QIDX_W    = 5;
    localparam int ENTRY_W   = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

endpackage

`default_nettype wire

// ----- rtl/multi_queue_priority_deque.sv -----
// Top level of the multi-queue priority deque: request sequencer and both memories.
//
//  Channel  | Direction | Handshake         | tuser               | tdata (low bit first)
//  ---------+-----------+-------------------+---------------------+----------------------------
//  s_ (req) | input     | s_tvalid/s_tready | kind [1:0]          | queue_index, entry_id, pad
//  m_ (res) | output    | m_tvalid/m_tready | outcome [1:0]       | taken_id, taken_urgent, pad
//
// An add, a reject or an ignored request has its queue-state memory read issued on
// acceptance and is evaluated and written back in ST_META. A take that finds an entry
// then passes through ST_SLOT for the registered read of the slot memory.
// Reset clears the per-queue valid bits at once, so no clearing pass is needed and a
// request may arrive in the first cycle after reset. A stalled result sits in the
// output register; the next request is still accepted and waits only when it has a
// result to deliver while the output register is full.
`default_nettype none

module multi_queue_priority_deque #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Request channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mqpd_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
    input  wire logic [mqpd_pkg::S_TDATA_W-1:0]  s_tdata,   // queue_index[4:0],
                                                            // entry_id[20:5], zero[23:21]
    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [1:0]                      m_tuser,   // outcome[1:0]
    output logic      [mqpd_pkg::M_TDATA_W-1:0]  m_tdata    // taken_id[15:0],
                                                            // taken_urgent[16], zero[23:17]
);

    // Widths that follow from the parameters.
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SW = $clog2(SLOTS);
    localparam int MW = FW + HW;
    localparam int DW = ID_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_SLOT
    } state_t;

    state_t state_reg;

    // Captured request.
    mqpd_pkg::kind_t              kind_reg;
    logic [mqpd_pkg::QIDX_W-1:0]  qidx_reg;
    logic [mqpd_pkg::ENTRY_W-1:0] id_reg;

    // Output register.
    logic                          m_tvalid_reg;
    mqpd_pkg::outcome_t            m_outcome_reg;
    logic [mqpd_pkg::ENTRY_W-1:0]  m_id_reg;
    logic                          m_urgent_reg;

    // Per-queue valid bits: a queue whose state word was never written reads as empty.
    logic [NUM_QUEUES-1:0] meta_valid_reg;
    logic                  meta_hit_reg;

    // Queue-state memory signals.
    logic          meta_rd_en;
    logic [QW-1:0] meta_rd_addr;
    logic [MW-1:0] meta_rd_data;
    logic          meta_wr_en;
    logic [QW-1:0] meta_wr_addr;
    logic [FW-1:0] meta_wr_fill;
    logic [HW-1:0] meta_wr_head;

    // Slot memory signals.
    logic          slot_rd_en;
    logic [SW-1:0] slot_rd_addr;
    logic [DW-1:0] slot_rd_data;
    logic          slot_wr_en;
    logic [SW-1:0] slot_wr_addr;
    logic [DW-1:0] slot_wr_data;

    // Evaluation of the captured request.
    logic          s_accept;
    logic          out_free;
    logic          load_result;
    logic          in_range;
    logic [QW-1:0] qa;
    logic [FW-1:0] cur_fill;
    logic [HW-1:0] cur_head;
    logic [HW:0]   tail_sum;
    logic [HW-1:0] tail_pos;
    logic [HW-1:0] head_dec;
    logic [HW-1:0] head_inc;
    logic [HW-1:0] slot_pos;
    logic [SW-1:0] slot_base;
    logic          take_hit;
    logic          is_full;
    logic          do_add;
    logic          meta_go;
    mqpd_pkg::outcome_t meta_outcome;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign qa       = QW'(qidx_reg);
    assign in_range = (32'(qidx_reg) < NUM_QUEUES);

    assign cur_fill = meta_hit_reg ? meta_rd_data[MW-1:HW] : '0;
    assign cur_head = meta_hit_reg ? meta_rd_data[HW-1:0]  : '0;

    // Circular arithmetic on slot positions; both sums stay below twice the depth.
    assign tail_sum = (HW+1)'(cur_head) + (HW+1)'(cur_fill);
    assign tail_pos = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
                    ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    assign head_dec = (cur_head == '0) ? HW'(QUEUE_DEPTH - 1) : cur_head - HW'(1);
    assign head_inc = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HW'(1);

    assign slot_base = SW'(qa) * SW'(QUEUE_DEPTH);

    assign is_full  = (cur_fill >= FW'(QUEUE_DEPTH));
    assign take_hit = in_range && (kind_reg == mqpd_pkg::KIND_TAKE) && (cur_fill != '0);
    assign do_add   = in_range && !is_full
                   && ((kind_reg == mqpd_pkg::KIND_ADD) || (kind_reg == mqpd_pkg::KIND_URGENT));

    // A take that finds an entry hands off to the slot read; everything else
    // produces its result here and needs the output register.
    assign meta_go = (state_reg == ST_META) && (take_hit || out_free);

    // The output register is loaded when either stage delivers a result.
    assign load_result = (meta_go && !take_hit) || ((state_reg == ST_SLOT) && out_free);

    always_comb begin
        if (do_add) begin
            meta_outcome = mqpd_pkg::OUT_ADDED;
        end else if ((kind_reg == mqpd_pkg::KIND_TAKE) || (kind_reg == mqpd_pkg::KIND_UNUSED)) begin
            meta_outcome = mqpd_pkg::OUT_EMPTY;
        end else begin
            meta_outcome = mqpd_pkg::OUT_FULL;
        end
    end

    assign slot_pos = (kind_reg == mqpd_pkg::KIND_URGENT) ? head_dec : tail_pos;

    // Queue-state read is issued with the request; write-back happens on leaving ST_META,
    // before the next request can be accepted, so no forwarding is needed.
    assign meta_rd_en   = s_accept;
    assign meta_rd_addr = QW'(s_tdata[mqpd_pkg::QIDX_W-1:0]);

    assign meta_wr_en   = meta_go && (take_hit || do_add);
    assign meta_wr_addr = qa;
    assign meta_wr_fill = take_hit ? cur_fill - FW'(1) : cur_fill + FW'(1);
    assign meta_wr_head = take_hit ? head_inc
                        : ((kind_reg == mqpd_pkg::KIND_URGENT) ? head_dec : cur_head);

    assign slot_rd_en   = meta_go && take_hit;
    assign slot_rd_addr = slot_base + SW'(cur_head);

    assign slot_wr_en   = meta_go && do_add;
    assign slot_wr_addr = slot_base + SW'(slot_pos);
    assign slot_wr_data = {ID_WIDTH'(id_reg), (kind_reg == mqpd_pkg::KIND_URGENT)};

    mqpd_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_QUEUES)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_wr_en),
        .wr_addr (meta_wr_addr),
        .wr_data ({meta_wr_fill, meta_wr_head}),
        .rd_en   (meta_rd_en),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd_data)
    );

    mqpd_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    // Request capture and valid-bit tracking.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg     <= mqpd_pkg::kind_t'(s_tuser);
            qidx_reg     <= s_tdata[mqpd_pkg::QIDX_W-1:0];
            id_reg       <= s_tdata[mqpd_pkg::QIDX_W +: mqpd_pkg::ENTRY_W];
            meta_hit_reg <= meta_valid_reg[meta_rd_addr];
        end
        if (!aresetn) begin
            meta_valid_reg <= '0;
        end else if (meta_wr_en) begin
            meta_valid_reg[meta_wr_addr] <= 1'b1;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_META;
                    end
                end
                ST_META: begin
                    if (meta_go) begin
                        if (take_hit) begin
                            state_reg <= ST_SLOT;
                        end else begin
                            state_reg     <= ST_IDLE;
                            m_outcome_reg <= meta_outcome;
                            m_id_reg      <= '0;
                            m_urgent_reg  <= 1'b0;
                        end
                    end
                end
                ST_SLOT: begin
                    if (out_free) begin
                        state_reg     <= ST_IDLE;
                        m_outcome_reg <= mqpd_pkg::OUT_TAKEN;
                        m_id_reg      <= mqpd_pkg::ENTRY_W'(slot_rd_data[DW-1:1]);
                        m_urgent_reg  <= slot_rd_data[0];
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {7'b0, m_urgent_reg, m_id_reg};

    // A request moves straight to evaluation after it is accepted.
    a_accept_to_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_META))
        else $error("accepted request did not enter evaluation");

    // The slot read stage is entered only from evaluation.
    a_slot_from_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOT) |-> ($past(state_reg) == ST_META || $past(state_reg) == ST_SLOT))
        else $error("slot stage entered out of order");

    // Queue-state write-back never records more entries than a queue holds.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_wr_en |-> (meta_wr_fill <= FW'(QUEUE_DEPTH)))
        else $error("queue fill written beyond depth");

    // The slot write of an add and the slot read of a take never occur together.
    a_slot_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(slot_wr_en && slot_rd_en))
        else $error("slot memory read and written for one request");

    // A result other than a take carries a zero id and a clear urgent flag.
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != mqpd_pkg::OUT_TAKEN)) |-> (m_tdata == '0))
        else $error("non-take result carries entry payload");

endmodule

`default_nettype wire

// ----- rtl/mqpd_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module mqpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
